[rtl/core/point_in_polygon_test_assert.svh]
// assertion macros for the point in polygon test block
// depends on nothing; included by the top level only
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define PIT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("point_in_polygon_test assertion failed");
// next-cycle implication, disabled while reset is low
`define PIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("point_in_polygon_test assertion failed");
`else
`define PIT_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pit_pkg.sv]
// shared constants and types for the point in polygon test block
// depends on nothing
package pit_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned THR_WIDTH       = 32;
  localparam logic [THR_WIDTH-1:0] NEAR_DIST_RESET = 32'd655;

  // control travelling alongside the product word
  typedef struct packed {
    logic valid;
    logic last;
    logic straddle;
    logic dy_pos;
  } pit_ctl_t;

endpackage

[rtl/core/pit_prod.sv]
// input register, coordinate differences and the six products of one edge
// depends on pit_pkg
module pit_prod #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_end_y,
  input  logic                          in_last_edge,
  input  logic                          dn_ready,
  output pit_pkg::pit_ctl_t             prod_ctl,
  output logic signed [2*COORD_WIDTH+1:0] sq_ax,
  output logic signed [2*COORD_WIDTH+1:0] sq_ay,
  output logic signed [2*COORD_WIDTH+1:0] sq_bx,
  output logic signed [2*COORD_WIDTH+1:0] sq_by,
  output logic signed [2*COORD_WIDTH+1:0] cross_t,
  output logic signed [2*COORD_WIDTH+1:0] cross_r
);
  import pit_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  // stage one: registered edge word
  logic                          s1_valid_r;
  logic                          s1_last_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic                          s1_en;
  logic                          s1_go;

  // differences
  logic signed [DW-1:0] dax, day, dbx, dby, ex, ey;
  logic                 straddle, dy_pos;

  // stage two: products
  logic                 s2_valid_r;
  logic                 s2_last_r;
  logic                 s2_straddle_r;
  logic                 s2_dy_pos_r;
  logic signed [PW-1:0] sq_ax_r, sq_ay_r, sq_bx_r, sq_by_r, t_r, r_r;
  logic                 s2_en;

  assign s2_en    = !s2_valid_r || dn_ready;
  assign s1_go    = s1_valid_r && s2_en;
  assign s1_en    = !s1_valid_r || s1_go;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_last_r <= in_last_edge;
      px_r      <= in_point_x;
      py_r      <= in_point_y;
      ax_r      <= in_edge_start_x;
      ay_r      <= in_edge_start_y;
      bx_r      <= in_edge_end_x;
      by_r      <= in_edge_end_y;
    end
  end

  always_comb begin
    dax      = DW'(px_r) - DW'(ax_r);
    day      = DW'(py_r) - DW'(ay_r);
    dbx      = DW'(px_r) - DW'(bx_r);
    dby      = DW'(py_r) - DW'(by_r);
    ex       = DW'(bx_r) - DW'(ax_r);
    ey       = DW'(by_r) - DW'(ay_r);
    // one end strictly below the point's y, the other at or above
    straddle = ((ay_r < py_r) && (by_r >= py_r)) || ((by_r < py_r) && (ay_r >= py_r));
    dy_pos   = by_r > ay_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_last_r     <= s1_last_r;
      s2_straddle_r <= straddle;
      s2_dy_pos_r   <= dy_pos;
      sq_ax_r       <= PW'(dax) * PW'(dax);
      sq_ay_r       <= PW'(day) * PW'(day);
      sq_bx_r       <= PW'(dbx) * PW'(dbx);
      sq_by_r       <= PW'(dby) * PW'(dby);
      t_r           <= PW'(day) * PW'(ex);
      r_r           <= PW'(dax) * PW'(ey);
    end
  end

  always_comb begin
    prod_ctl.valid    = s2_valid_r;
    prod_ctl.last     = s2_last_r;
    prod_ctl.straddle = s2_straddle_r;
    prod_ctl.dy_pos   = s2_dy_pos_r;
  end

  assign sq_ax    = sq_ax_r;
  assign sq_ay    = sq_ay_r;
  assign sq_bx    = sq_bx_r;
  assign sq_by    = sq_by_r;
  assign cross_t  = t_r;
  assign cross_r  = r_r;

endmodule

[rtl/core/pit_acc.sv]
// proximity and crossing compares, parity and near state, result register
// depends on pit_pkg
module pit_acc #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pit_pkg::pit_ctl_t               prod_ctl,
  input  logic signed [2*COORD_WIDTH+1:0] sq_ax,
  input  logic signed [2*COORD_WIDTH+1:0] sq_ay,
  input  logic signed [2*COORD_WIDTH+1:0] sq_bx,
  input  logic signed [2*COORD_WIDTH+1:0] sq_by,
  input  logic signed [2*COORD_WIDTH+1:0] cross_t,
  input  logic signed [2*COORD_WIDTH+1:0] cross_r,
  input  logic [pit_pkg::THR_WIDTH-1:0]   near_dist_sq,
  output logic                            dn_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_inside_res,
  output logic                            out_near_vertex
);
  import pit_pkg::*;

  localparam int unsigned PW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SW = (PW > THR_WIDTH) ? PW : THR_WIDTH;

  logic [SW-1:0] sum_a, sum_b, thr;
  logic          near_now, left, toggle;
  logic          parity_r, parity_nxt;
  logic          near_r, near_nxt;
  logic          go;
  logic          out_valid_r;
  logic          inside_r, vertex_r;

  // squares are non-negative, so their low bits sum without overflow at SW
  always_comb begin
    thr      = SW'(near_dist_sq);
    sum_a    = SW'(unsigned'(sq_ax)) + SW'(unsigned'(sq_ay));
    sum_b    = SW'(unsigned'(sq_bx)) + SW'(unsigned'(sq_by));
    near_now = (sum_a < thr) || (sum_b < thr);
    left     = prod_ctl.dy_pos ? (cross_t < cross_r) : (cross_r < cross_t);
    toggle   = prod_ctl.straddle && left;
    parity_nxt = parity_r ^ toggle;
    near_nxt   = near_r | near_now;
  end

  // a non-last edge never waits on the result side
  assign go       = prod_ctl.valid && (!prod_ctl.last || !out_valid_r || out_ready);
  assign dn_ready = !prod_ctl.valid || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
      near_r   <= 1'b0;
    end else if (go) begin
      if (prod_ctl.last) begin
        parity_r <= 1'b0;
        near_r   <= 1'b0;
      end else begin
        parity_r <= parity_nxt;
        near_r   <= near_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && prod_ctl.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && prod_ctl.last) begin
      inside_r <= near_nxt | parity_nxt;
      vertex_r <= near_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inside_res  = inside_r;
  assign out_near_vertex = vertex_r;

endmodule

[rtl/core/point_in_polygon_test.sv]
// point in polygon test by even-odd ray casting, one polygon edge per word
// a last-edge word passes the input register, the product register and the result register
// throughput: one edge word per cycle while no result stalls, set by the single multiply stage
// a waiting result stalls a last-edge word and the edges behind it; other edges keep flowing
// reset (synchronous, active low) clears parity, near flag and all valids;
// the threshold register returns to 655 (about 0.01 in Q16.16)
`include "point_in_polygon_test_assert.svh"
module point_in_polygon_test #(
  parameter int unsigned COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // edge words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_edge_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_edge_end_y,
  input  logic                          in_last_edge,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside_res,
  output logic                          out_near_vertex,
  // threshold write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pit_pkg::THR_WIDTH-1:0] cfg_near_dist_sq
);
  import pit_pkg::*;

  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  logic [THR_WIDTH-1:0] near_dist_sq_r;
  pit_ctl_t             prod_ctl;
  logic signed [PW-1:0] sq_ax, sq_ay, sq_bx, sq_by, cross_t, cross_r;
  logic                 dn_ready;

  // threshold register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_dist_sq_r <= NEAR_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      near_dist_sq_r <= cfg_near_dist_sq;
    end
  end

  // input register, differences, products
  pit_prod #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_prod (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_edge_start_x (in_edge_start_x),
    .in_edge_start_y (in_edge_start_y),
    .in_edge_end_x   (in_edge_end_x),
    .in_edge_end_y   (in_edge_end_y),
    .in_last_edge    (in_last_edge),
    .dn_ready        (dn_ready),
    .prod_ctl        (prod_ctl),
    .sq_ax           (sq_ax),
    .sq_ay           (sq_ay),
    .sq_bx           (sq_bx),
    .sq_by           (sq_by),
    .cross_t         (cross_t),
    .cross_r         (cross_r)
  );

  // compares, state update and result register
  pit_acc #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_acc (
    .clk             (clk),
    .rst_n           (rst_n),
    .prod_ctl        (prod_ctl),
    .sq_ax           (sq_ax),
    .sq_ay           (sq_ay),
    .sq_bx           (sq_bx),
    .sq_by           (sq_by),
    .cross_t         (cross_t),
    .cross_r         (cross_r),
    .near_dist_sq    (near_dist_sq_r),
    .dn_ready        (dn_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inside_res  (out_inside_res),
    .out_near_vertex (out_near_vertex)
  );

  // a near vertex always reports inside
  `PIT_ASSERT_SAME(a_near_implies_inside, clk, rst_n, out_valid, !out_near_vertex || out_inside_res)
  // with no result pending the pipeline can always take an edge
  `PIT_ASSERT_SAME(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)
  // an empty result register stays empty while no edge reaches the last stage
  `PIT_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !out_valid && !prod_ctl.valid, !out_valid)

endmodule
